// File: rtl/lic_pkg.sv
// Shared types and constants for the interrupt controller.
package lic_pkg;

  localparam int SOURCES_DEF = 16;
  localparam int DATA_W = 32;
  localparam int GLOBAL_EN_BIT = 31;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2
  } cmd_t;

  typedef logic [2:0] reg_sel_t;

  localparam reg_sel_t REG_CONTROL  = 3'd0;
  localparam reg_sel_t REG_ENABLE   = 3'd1;
  localparam reg_sel_t REG_STATUS   = 3'd2;
  localparam reg_sel_t REG_CLEAR    = 3'd3;
  localparam reg_sel_t REG_POLARITY = 3'd4;

  typedef struct packed {
    cmd_t     cmd;
    reg_sel_t offset;
  } acc_t;

endpackage

// File: rtl/lic_in_stage.sv
// Input register stage that holds one request until the core consumes it.
module lic_in_stage #(
  parameter int SOURCES = lic_pkg::SOURCES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lic_pkg::acc_t             in_acc,
  input  logic [lic_pkg::DATA_W-1:0] in_wdata,
  input  logic [SOURCES-1:0]        in_levels,
  input  logic                      take_ok,
  output logic                      adv,
  output lic_pkg::acc_t             s1_acc,
  output logic [lic_pkg::DATA_W-1:0] s1_wdata,
  output logic [SOURCES-1:0]        s1_levels
);

  logic                       valid_r;
  lic_pkg::acc_t              acc_r;
  logic [lic_pkg::DATA_W-1:0] wdata_r;
  logic [SOURCES-1:0]         levels_r;
  logic                       load;

  assign adv      = valid_r && take_ok;
  assign in_stall = valid_r && !take_ok;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r    <= in_acc;
      wdata_r  <= in_wdata;
      levels_r <= in_levels;
    end
  end

  assign s1_acc    = acc_r;
  assign s1_wdata  = wdata_r;
  assign s1_levels = levels_r;

endmodule

// File: rtl/lic_core.sv
// Register file, bus access and source sampling for one request.
module lic_core #(
  parameter int SOURCES = lic_pkg::SOURCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  lic_pkg::acc_t              acc,
  input  logic [lic_pkg::DATA_W-1:0] wdata,
  input  logic [SOURCES-1:0]         levels,
  output logic [lic_pkg::DATA_W-1:0] rdata_nxt,
  output logic [SOURCES-1:0]         pending_nxt,
  output logic                       irq_nxt
);

  logic [lic_pkg::DATA_W-1:0] control_r, control_nxt;
  logic [SOURCES-1:0]         enable_r, enable_nxt;
  logic [SOURCES-1:0]         status_r, status_nxt;
  logic [SOURCES-1:0]         polarity_r, polarity_nxt;
  logic [SOURCES-1:0]         cleared;
  logic                       is_wr;

  assign is_wr = (acc.cmd == lic_pkg::CMD_WRITE);

  always_comb begin
    rdata_nxt = '0;
    if (acc.cmd == lic_pkg::CMD_READ) begin
      unique case (acc.offset)
        lic_pkg::REG_CONTROL:  rdata_nxt = control_r;
        lic_pkg::REG_ENABLE:   rdata_nxt[SOURCES-1:0] = enable_r;
        lic_pkg::REG_STATUS:   rdata_nxt[SOURCES-1:0] = status_r;
        lic_pkg::REG_POLARITY: rdata_nxt[SOURCES-1:0] = polarity_r;
        default:               rdata_nxt = '0;
      endcase
    end
  end

  always_comb begin
    control_nxt  = control_r;
    enable_nxt   = enable_r;
    polarity_nxt = polarity_r;
    cleared      = status_r;
    if (is_wr) begin
      unique case (acc.offset)
        lic_pkg::REG_CONTROL:  control_nxt = wdata;
        lic_pkg::REG_ENABLE:   enable_nxt = wdata[SOURCES-1:0];
        lic_pkg::REG_CLEAR:    cleared = status_r & ~wdata[SOURCES-1:0];
        lic_pkg::REG_POLARITY: polarity_nxt = wdata[SOURCES-1:0];
        default:               cleared = status_r;
      endcase
    end
    status_nxt  = cleared | ~(levels ^ polarity_nxt);
    pending_nxt = status_nxt & enable_nxt;
    irq_nxt     = control_nxt[lic_pkg::GLOBAL_EN_BIT] && (pending_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r  <= '0;
      enable_r   <= '0;
      status_r   <= '0;
      polarity_r <= '0;
    end else if (adv) begin
      control_r  <= control_nxt;
      enable_r   <= enable_nxt;
      status_r   <= status_nxt;
      polarity_r <= polarity_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pol_write: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_wr && acc.offset == lic_pkg::REG_POLARITY
    |=> polarity_r == $past(wdata[SOURCES-1:0]))
    else $error("polarity write not taken");

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !(is_wr && acc.offset == lic_pkg::REG_CLEAR)
    |=> (status_r & $past(status_r)) == $past(status_r))
    else $error("status bit lost without a clear");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(control_r) && $stable(status_r) && $stable(enable_r))
    else $error("state changed without a request");
`endif

endmodule

// File: rtl/lic_out_stage.sv
// Result register that holds one finished result until it is taken.
module lic_out_stage #(
  parameter int SOURCES = lic_pkg::SOURCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [lic_pkg::DATA_W-1:0] rdata_nxt,
  input  logic [SOURCES-1:0]         pending_nxt,
  input  logic                       irq_nxt,
  output logic                       take_ok,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lic_pkg::DATA_W-1:0] out_read_data,
  output logic [SOURCES-1:0]         out_pending_bits,
  output logic                       out_irq_out
);

  logic                       valid_r;
  logic [lic_pkg::DATA_W-1:0] rdata_r;
  logic [SOURCES-1:0]         pending_r;
  logic                       irq_r;

  assign take_ok = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_ok) begin
      valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r   <= rdata_nxt;
      pending_r <= pending_nxt;
      irq_r     <= irq_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_read_data    = rdata_r;
  assign out_pending_bits = pending_r;
  assign out_irq_out      = irq_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |-> !adv)
    else $error("held result overwritten");

  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> valid_r)
    else $error("result dropped");

  a_irq_pending: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && irq_r |-> pending_r != '0)
    else $error("interrupt without pending source");
`endif

endmodule

// File: rtl/lpc_interrupt_controller_top.sv
// Top level of the interrupt controller with mask, status and polarity.
// Each request is a sample of the source lines, optionally with one register
// read or write; it is captured in an input register, served and sampled
// against the register file, and its result lands in an output register.
// One request is taken every clock cycle unless the output stalls, and a
// stalled result holds the pipeline.
module lpc_interrupt_controller_top #(
  parameter int SOURCES = lic_pkg::SOURCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [2:0]                 in_reg_offset,
  input  logic [lic_pkg::DATA_W-1:0] in_write_data,
  input  logic [SOURCES-1:0]         in_source_levels,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lic_pkg::DATA_W-1:0] out_read_data,
  output logic [SOURCES-1:0]         out_pending_bits,
  output logic                       out_irq_out
);

  lic_pkg::acc_t              in_acc;
  lic_pkg::acc_t              s1_acc;
  logic [lic_pkg::DATA_W-1:0] s1_wdata;
  logic [SOURCES-1:0]         s1_levels;
  logic                       take_ok;
  logic                       adv;
  logic [lic_pkg::DATA_W-1:0] rdata_nxt;
  logic [SOURCES-1:0]         pending_nxt;
  logic                       irq_nxt;

  assign in_acc.cmd    = lic_pkg::cmd_t'(in_command);
  assign in_acc.offset = in_reg_offset;

  lic_in_stage #(.SOURCES(SOURCES)) u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_acc    (in_acc),
    .in_wdata  (in_write_data),
    .in_levels (in_source_levels),
    .take_ok   (take_ok),
    .adv       (adv),
    .s1_acc    (s1_acc),
    .s1_wdata  (s1_wdata),
    .s1_levels (s1_levels)
  );

  lic_core #(.SOURCES(SOURCES)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .acc         (s1_acc),
    .wdata       (s1_wdata),
    .levels      (s1_levels),
    .rdata_nxt   (rdata_nxt),
    .pending_nxt (pending_nxt),
    .irq_nxt     (irq_nxt)
  );

  lic_out_stage #(.SOURCES(SOURCES)) u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .rdata_nxt        (rdata_nxt),
    .pending_nxt      (pending_nxt),
    .irq_nxt          (irq_nxt),
    .take_ok          (take_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_pending_bits (out_pending_bits),
    .out_irq_out      (out_irq_out)
  );

endmodule
